>>> hw/rtl/zsd_pkg.sv
// Package for the ZMODEM subpacket deframer: result kinds, protocol byte codes
// and the byte-wide CRC-16 update. No dependencies.
package zsd_pkg;

   // Field widths fixed by the result format.
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 10;
   localparam int OFFSET_W = 32;
   localparam int CRC_W    = 16;

   // Protocol byte codes.
   localparam logic [BYTE_W-1:0] ZDLE_BYTE  = 8'h18;
   localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h40;
   localparam logic [BYTE_W-1:0] END_FINAL  = 8'h45;
   localparam logic [BYTE_W-1:0] END_MORE   = 8'h47;

   // CRC-16 XMODEM polynomial and top bit.
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_OVER = 2'd3
   } kind_type;

   // Feeds one byte into the CRC, most significant bit first.
   function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if ((acc & CRC_TOP) != '0) begin
            acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[CRC_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

>>> hw/rtl/zsd_if.sv
// Valid/ready channel interfaces for the ZMODEM subpacket deframer.
// Depends on zsd_pkg for field widths and the result kind type.
interface zsd_req_if;
   import zsd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface zsd_rsp_if;
   import zsd_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [BYTE_W-1:0]   data_byte;
   logic [LEN_W-1:0]    payload_length;
   logic [OFFSET_W-1:0] file_offset;
   logic                frame_final;

   modport source (output valid, output kind, output data_byte, output payload_length,
                   output file_offset, output frame_final, input ready);
   modport sink   (input valid, input kind, input data_byte, input payload_length,
                   input file_offset, input frame_final, output ready);
endinterface

>>> hw/rtl/zmodem_subpacket_deframer.sv
// ZMODEM CRC-16 data subpacket deframer, top level.
// Depends on zsd_pkg and the channel interfaces in zsd_if.sv.
// A byte in the input register passes its result, if any, to the result register once that is free.
// Throughput: one byte per cycle unless a result waits; the input and result registers each
// hold one transaction, so a waiting result lets only one more byte into the input register.
// Reset: synchronous, active high; clears the valid bits, the escape/CRC phase, the CRC,
// the byte count, the committed offset and the sticky overflow error.
module zmodem_subpacket_deframer #(
   parameter int MAX_PAYLOAD = 512
) (
   input logic        clock,
   input logic        reset,
   zsd_req_if.sink    req_bus,
   zsd_rsp_if.source  rsp_bus
);
   import zsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [1:0] {
      PH_DATA,
      PH_ESC,
      PH_CRC_HI,
      PH_CRC_LO
   } phase_type;

   // Input stage.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Deframer state.
   phase_type           phase_ff, phase_in;
   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]   crc_hi_ff, crc_hi_in;
   logic                final_ff, final_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                error_ff, error_in;

   // Result register.
   logic                out_valid_ff;
   kind_type            out_kind_ff, res_kind;
   logic [BYTE_W-1:0]   out_data_ff, res_data;
   logic [LEN_W-1:0]    out_len_ff, res_len;
   logic [OFFSET_W-1:0] out_offset_ff, res_offset;
   logic                out_final_ff, res_final;
   logic                res_valid;

   // Handshake and stage advance.
   logic              out_free;
   logic              advance;
   logic              req_fire;

   // Per-byte helpers.
   logic [BYTE_W-1:0]   pay_byte;
   logic [OFFSET_W-1:0] offset_sum;
   logic                is_end;
   logic                overflow;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   // Escape removal, end marker detection, overflow check and offset sum.
   assign pay_byte   = (phase_ff == PH_ESC) ? (in_byte_ff ^ ESC_XOR) : in_byte_ff;
   assign is_end     = (in_byte_ff == END_FINAL) || (in_byte_ff == END_MORE);
   assign overflow   = (count_ff >= CNT_W'(MAX_PAYLOAD));
   assign offset_sum = offset_ff + OFFSET_W'(count_ff);

   // Next state and result for the byte in the input stage.
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      count_in   = count_ff;
      crc_hi_in  = crc_hi_ff;
      final_in   = final_ff;
      offset_in  = offset_ff;
      error_in   = error_ff;
      res_valid  = 1'b0;
      res_kind   = KIND_DATA;
      res_data   = '0;
      res_len    = '0;
      res_offset = offset_ff;
      res_final  = 1'b0;

      if (!error_ff) begin
         case (phase_ff)
            PH_DATA, PH_ESC: begin
               if (phase_ff == PH_DATA && in_byte_ff == ZDLE_BYTE) begin
                  phase_in = PH_ESC;
               end else if (phase_ff == PH_ESC && is_end) begin
                  crc_in   = crc16_feed(crc_ff, in_byte_ff);
                  final_in = (in_byte_ff == END_FINAL);
                  phase_in = PH_CRC_HI;
               end else begin
                  // Payload byte, or the overflow that drops it.
                  phase_in  = PH_DATA;
                  res_valid = 1'b1;
                  if (overflow) begin
                     error_in = 1'b1;
                     res_kind = KIND_OVER;
                     res_len  = LEN_W'(count_ff);
                  end else begin
                     crc_in   = crc16_feed(crc_ff, pay_byte);
                     count_in = count_ff + 1'b1;
                     res_data = pay_byte;
                  end
               end
            end
            PH_CRC_HI: begin
               crc_hi_in = in_byte_ff;
               phase_in  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               res_valid = 1'b1;
               res_len   = LEN_W'(count_ff);
               res_final = final_ff;
               if ({crc_hi_ff, in_byte_ff} == crc_ff) begin
                  res_kind   = KIND_GOOD;
                  offset_in  = offset_sum;
                  res_offset = offset_sum;
               end else begin
                  res_kind = KIND_BAD;
               end
               crc_in   = '0;
               count_in = '0;
               phase_in = PH_DATA;
            end
            default: begin
               phase_in = PH_DATA;
            end
         endcase
      end
   end

   // State, input stage and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_DATA;
         crc_ff       <= '0;
         count_ff     <= '0;
         crc_hi_ff    <= '0;
         final_ff     <= 1'b0;
         offset_ff    <= '0;
         error_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            crc_ff       <= crc_in;
            count_ff     <= count_in;
            crc_hi_ff    <= crc_hi_in;
            final_ff     <= final_in;
            offset_ff    <= offset_in;
            error_ff     <= error_in;
            out_valid_ff <= res_valid;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance && res_valid) begin
         out_kind_ff   <= res_kind;
         out_data_ff   <= res_data;
         out_len_ff    <= res_len;
         out_offset_ff <= res_offset;
         out_final_ff  <= res_final;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.kind           = out_kind_ff;
   assign rsp_bus.data_byte      = out_data_ff;
   assign rsp_bus.payload_length = out_len_ff;
   assign rsp_bus.file_offset    = out_offset_ff;
   assign rsp_bus.frame_final    = out_final_ff;

endmodule

>>> hw/rtl/zsd_checker.sv
// Port-level assertions for the ZMODEM subpacket deframer, and their bind.
// Depends on zsd_pkg and on zmodem_subpacket_deframer for the bind.
module zsd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input zsd_pkg::kind_type           kind,
   input logic [zsd_pkg::BYTE_W-1:0]  data_byte,
   input logic [zsd_pkg::LEN_W-1:0]   payload_length,
   input logic [zsd_pkg::OFFSET_W-1:0] file_offset,
   input logic                        frame_final
);
   import zsd_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(data_byte)
         && $stable(payload_length) && $stable(file_offset) && $stable(frame_final))
      else $error("result changed while stalled");

   // A tentative data byte carries no length and no end marker flag.
   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_DATA |-> payload_length == '0 && frame_final == 1'b0)
      else $error("data result carries frame fields");

   // An overflow result carries neither data nor an end marker flag.
   a_over_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_OVER |-> data_byte == '0 && frame_final == 1'b0)
      else $error("overflow result carries data");

   // The overflow error is sticky: nothing follows it until reset.
   a_over_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && kind == KIND_OVER |=> !rsp_valid)
      else $error("result after overflow error");

endmodule

bind zmodem_subpacket_deframer zsd_checker u_zsd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .kind           (rsp_bus.kind),
   .data_byte      (rsp_bus.data_byte),
   .payload_length (rsp_bus.payload_length),
   .file_offset    (rsp_bus.file_offset),
   .frame_final    (rsp_bus.frame_final)
);
